/* hdl/ffpa_pkg.sv */
// Package for the first-fit pool allocator: widths, status codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package ffpa_pkg;
	localparam int POOL_BYTES_DEF   = 65536;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int ALIGN_BYTES_DEF  = 8;
	localparam int MAX_BLOCKS_DEF   = 64;

	localparam int SIZE_W = 17;
	localparam int ADDR_W = 16;
	localparam int USED_W = 17;
	localparam int STAT_W = 2;
	localparam int OFF_W  = 22;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture request, clear index
		logic rd;         // issue table read at index
		logic step;       // advance index
		logic shift_rd;   // read entry for shifting
		logic shift_wr;   // write shifted entry
		logic ins_wr;     // write new entry
		logic commit;     // update count/used, form result
		logic fail;       // form failure result
	} ffpa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_free;
		logic reject;     // too large or table full
		logic empty;
		logic scan_last;  // last entry (free) or tail gap (alloc) checked
		logic hit;        // scan found gap / match
		logic shift_done;
	} ffpa_stat_t;
endpackage
`default_nettype wire

/* hdl/ffpa_datapath.sv */
// Datapath of the first-fit pool allocator: block table memory, scan index,
// fit and match checks, shifting, used-byte counter. Uses ffpa_pkg.
`default_nettype none
module ffpa_datapath
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES   = POOL_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_action,
	input  wire logic [SIZE_W-1:0] in_size,
	input  wire logic [ADDR_W-1:0] in_baddr,
	input  wire ffpa_cmd_t         cmd,
	output ffpa_stat_t             stat,
	output logic [STAT_W-1:0]      res_status,
	output logic [ADDR_W-1:0]      res_addr,
	output logic [USED_W-1:0]      res_used
);
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int PW    = $clog2(POOL_BYTES + 1) + 1;
	localparam int LIM_W = PW + 1;
	localparam logic [LIM_W-1:0] POOL_L = LIM_W'(POOL_BYTES);
	localparam logic [LIM_W-1:0] HDR_L  = LIM_W'(HEADER_BYTES);
	localparam logic [LIM_W-1:0] ALN_L  = LIM_W'(ALIGN_BYTES);
	localparam bit ALN_P2 = (ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0;
	// reciprocal of the alignment, exact for any offset below 2**LIM_W
	localparam int SH    = LIM_W + 7;
	localparam int PRD_W = LIM_W + SH + 1;
	localparam logic [SH:0] RECIP = (SH+1)'(((longint'(1) << SH) +
		longint'(ALIGN_BYTES) - longint'(1)) / longint'(ALIGN_BYTES));

	logic [LIM_W-1:0] mem_start [MAX_BLOCKS];
	logic [SIZE_W-1:0] mem_len [MAX_BLOCKS];

	logic [CNT_W-1:0] count_q;
	logic [USED_W-1:0] used_q;
	logic action_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] baddr_q;
	logic [CNT_W-1:0] idx_q;      // entry being examined
	logic [LIM_W-1:0] prev_end_q; // end of previous block (0 before first)
	logic [LIM_W-1:0] rd_start_q;
	logic [SIZE_W-1:0] rd_len_q;
	logic [CNT_W-1:0] pos_q;      // insert / remove position
	logic [LIM_W-1:0] at_q;
	logic [SIZE_W-1:0] flen_q;
	logic found_q, past_q;
	logic tail_q;                 // gap after the last block checked
	logic [CNT_W-1:0] sh_q;       // shift cursor
	logic [LIM_W-1:0] sh_start_q;
	logic [SIZE_W-1:0] sh_len_q;

	logic [LIM_W-1:0] need;
	assign need = LIM_W'(size_q) + HDR_L;

	// gap [prev_end, limit); limit is next start or pool end once past last
	logic [LIM_W-1:0] limit, from_a, rem;
	logic [PRD_W-1:0] prod;
	logic [LIM_W-1:0] quo;
	assign limit = past_q ? POOL_L : rd_start_q;
	always_comb begin
		if (ALN_P2) begin
			prod = '0;
			quo  = '0;
			rem  = prev_end_q & (ALN_L - LIM_W'(1));
		end else begin
			prod = PRD_W'(prev_end_q) * PRD_W'(RECIP);
			quo  = LIM_W'(prod >> SH);
			rem  = prev_end_q - quo * ALN_L;
		end
		from_a = (rem == '0) ? prev_end_q : prev_end_q + (ALN_L - rem);
	end
	logic fit;
	assign fit = (from_a <= limit) && ((limit - from_a) >= need);
	logic match;
	assign match = ADDR_W'(rd_start_q + HDR_L) == baddr_q;

	// shift source: alloc reads sh-1 into sh, free reads sh+1 into sh
	logic [CNT_W-1:0] src_idx;
	assign src_idx = (action_q == ACT_FREE) ? sh_q + CNT_W'(1) : sh_q - CNT_W'(1);

	logic [IDX_W-1:0] rd_idx;
	assign rd_idx = cmd.shift_rd ? src_idx[IDX_W-1:0] : idx_q[IDX_W-1:0];

	// table memory: registered read, one write port
	always_ff @(posedge clk) begin
		if (cmd.rd || cmd.shift_rd) begin
			rd_start_q <= mem_start[rd_idx];
			rd_len_q   <= mem_len[rd_idx];
		end
		if (cmd.shift_wr) begin
			mem_start[sh_q[IDX_W-1:0]] <= sh_start_q;
			mem_len[sh_q[IDX_W-1:0]]   <= sh_len_q;
		end else if (cmd.ins_wr) begin
			mem_start[pos_q[IDX_W-1:0]] <= at_q;
			mem_len[pos_q[IDX_W-1:0]]   <= size_q;
		end
	end

	// scan and shift bookkeeping; shifting moves one entry per read and write
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q   <= in_action;
			size_q     <= in_size;
			baddr_q    <= in_baddr;
			idx_q      <= '0;
			prev_end_q <= '0;
			found_q    <= 1'b0;
			past_q     <= (count_q == '0);
			tail_q     <= 1'b0;
		end else if (cmd.step) begin
			if (!found_q && ((action_q == ACT_ALLOC && fit) ||
			                (action_q == ACT_FREE && !past_q && match))) begin
				found_q <= 1'b1;
				pos_q   <= idx_q;
				at_q    <= from_a;
				flen_q  <= rd_len_q;
				// alloc shifts up from the top, free shifts down from the hole
				sh_q    <= (action_q == ACT_FREE) ? idx_q : count_q;
			end
			prev_end_q <= rd_start_q + LIM_W'(rd_len_q) + HDR_L;
			if (idx_q + CNT_W'(1) >= count_q) past_q <= 1'b1;
			if (past_q) tail_q <= 1'b1;
			idx_q <= idx_q + CNT_W'(1);
		end
		if (cmd.shift_rd) begin
			// nothing to latch beyond memory read
		end
		if (cmd.shift_wr)
			sh_q <= (action_q == ACT_FREE) ? sh_q + CNT_W'(1) : sh_q - CNT_W'(1);
	end

	always_comb begin
		sh_start_q = rd_start_q;
		sh_len_q   = rd_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			used_q  <= '0;
		end else if (cmd.commit) begin
			if (action_q == ACT_ALLOC) begin
				count_q <= count_q + CNT_W'(1);
				used_q  <= used_q + USED_W'(need);
			end else begin
				count_q <= count_q - CNT_W'(1);
				used_q  <= used_q - USED_W'(LIM_W'(flen_q) + HDR_L);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status <= ST_OK;
			res_addr   <= (action_q == ACT_ALLOC) ? ADDR_W'(at_q + HDR_L) : '0;
			res_used   <= (action_q == ACT_ALLOC) ? used_q + USED_W'(need)
			              : used_q - USED_W'(LIM_W'(flen_q) + HDR_L);
		end else if (cmd.fail) begin
			res_status <= (action_q == ACT_FREE) ? ST_UNKNOWN : ST_NOMEM;
			res_addr   <= '0;
			res_used   <= used_q;
		end
	end

	always_comb begin
		stat.is_free    = action_q;
		stat.reject     = (need > POOL_L) || (count_q >= CNT_W'(MAX_BLOCKS));
		stat.empty      = count_q == '0;
		stat.scan_last  = (action_q == ACT_FREE) ? past_q : tail_q;
		stat.hit        = found_q;
		stat.shift_done = (action_q == ACT_FREE) ? (sh_q + CNT_W'(1) >= count_q)
		                  : (sh_q <= pos_q);
	end
endmodule
`default_nettype wire

/* hdl/ffpa_ctrl.sv */
// Controller of the first-fit pool allocator: sequences scan, shift and
// commit over the datapath. Uses ffpa_pkg.
`default_nettype none
module ffpa_ctrl
	import ffpa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_fire,
	output logic       in_ready,
	input  wire logic  out_ready,
	output logic       out_valid,
	input  ffpa_stat_t stat,
	output ffpa_cmd_t  cmd
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_READ  = 7'b0000100,
		S_EVAL  = 7'b0001000,
		S_SHRD  = 7'b0010000,
		S_SHWR  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;
	state_t state_q, state_d;
	logic out_valid_q;
	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_fire) begin
				cmd.load = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!stat.is_free && stat.reject) begin
					cmd.fail = 1'b1;
					state_d = S_DONE;
				end else if (stat.empty && stat.is_free) begin
					cmd.fail = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.step = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (stat.hit) state_d = S_SHRD;
				else if (stat.scan_last) begin
					cmd.fail = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_READ;
				end
			end
			S_SHRD: begin
				if (stat.shift_done) begin
					if (!stat.is_free) cmd.ins_wr = 1'b1;
					cmd.commit = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.shift_wr = 1'b1;
				state_d = S_SHRD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE)
		else $error("accept while busy");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_valid_q)
		else $error("result lost");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.shift_wr && cmd.ins_wr))
		else $error("double write");
endmodule
`default_nettype wire

/* hdl/first_fit_pool_allocator.sv */
// Top level of the first-fit pool allocator: stream ports, controller and
// datapath. Depends on ffpa_pkg, ffpa_ctrl, ffpa_datapath.
`default_nettype none
// One request at a time. An allocate checks the gaps of the address-ordered
// block table one at a time (registered memory read, then fit check):
// before each block in turn, then after the last block. Once a gap fits, the
// entries above it move up one slot, each by a read and then a write; a free
// scans for the matching data offset and closes the hole the same way. The
// input opens again in the cycle after the result is taken. For N gaps or
// entries checked and M entries moved, N + M never exceeds the block count
// plus one. The table has no reset: only entries below the block count are
// ever used.
module first_fit_pool_allocator
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES   = POOL_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // action[0], alloc_size[17:1], block_address[33:18]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // status[1:0], data_address[17:2], used_bytes[34:18]
);
	ffpa_cmd_t cmd;
	ffpa_stat_t stat;
	logic [STAT_W-1:0] res_status;
	logic [ADDR_W-1:0] res_addr;
	logic [USED_W-1:0] res_used;
	logic fire;
	logic [5:0] unused_pad;

	assign fire = s_tvalid && s_tready;
	assign unused_pad = s_tdata[39:34];
	assign m_tdata = {5'd0, res_used, res_addr, res_status};

	ffpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire), .in_ready(s_tready),
		.out_ready(m_tready), .out_valid(m_tvalid), .stat(stat), .cmd(cmd)
	);

	ffpa_datapath #(
		.POOL_BYTES(POOL_BYTES), .HEADER_BYTES(HEADER_BYTES),
		.ALIGN_BYTES(ALIGN_BYTES), .MAX_BLOCKS(MAX_BLOCKS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_action(s_tdata[0]),
		.in_size(s_tdata[17:1]), .in_baddr(s_tdata[33:18]), .cmd(cmd),
		.stat(stat), .res_status(res_status), .res_addr(res_addr),
		.res_used(res_used)
	);
endmodule
`default_nettype wire
